/* sv/hrct_pkg.sv */
`default_nettype none
package hrct_pkg;

  // table geometry
  localparam int BUCKETS        = 4096;
  localparam int CAPACITY       = 16384;
  localparam int MAX_NAME_BYTES = 8;

  // field widths
  localparam int NAME_W   = 64;
  localparam int LEN_W    = 4;
  localparam int STATUS_W = 3;
  localparam int BYTE_W   = 8;

  // derived widths (bucket count is a power of two)
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // polynomial hash multiplier
  localparam int HashMult = 131;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_CALL   = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_REPEAT   = 3'd1,
    ST_WRONG    = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_RESP
  } state_e;

  // chain pointer with valid bit
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } ref_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic              called;
    ref_t              next;
  } entry_t;

  // sequencer to store
  typedef struct packed {
    logic [BUCKET_W-1:0] head_raddr;
    logic                head_we;
    logic [BUCKET_W-1:0] head_waddr;
    ref_t                head_wdata;
    logic [IDX_W-1:0]    ent_raddr;
    logic                ent_we;
    logic [IDX_W-1:0]    ent_waddr;
    entry_t              ent_wdata;
  } store_cmd_t;

  // store to sequencer
  typedef struct packed {
    ref_t   head;
    entry_t ent;
    logic   clearing;
  } store_rsp_t;

endpackage
`default_nettype wire

/* sv/hrct_hash.sv */
`default_nettype none
module hrct_hash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           step_i,
  input  logic [hrct_pkg::NAME_W-1:0]    name_i,
  input  logic [hrct_pkg::LEN_W-1:0]     len_i,
  output logic                           done_o,
  output logic [hrct_pkg::BUCKET_W-1:0]  bucket_o
);
  import hrct_pkg::*;

  logic [BUCKET_W-1:0] h_q, h_d;
  logic [LEN_W-1:0]    idx_q, idx_d;
  logic [BYTE_W-1:0]   cur_byte;

  // only the low bucket bits of the 64-bit hash matter, so keep just those
  assign cur_byte = name_i[idx_q[2:0]*BYTE_W +: BYTE_W];
  assign done_o   = (idx_q == len_i);
  assign bucket_o = h_q;

  // one byte per cycle through the single multiply-add
  always_comb begin
    h_d   = h_q;
    idx_d = idx_q;
    if (start_i) begin
      h_d   = '0;
      idx_d = '0;
    end else if (step_i && !done_o) begin
      h_d   = BUCKET_W'(h_q * BUCKET_W'(HashMult) + BUCKET_W'(cur_byte));
      idx_d = idx_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= '0;
      idx_q <= '0;
    end else begin
      h_q   <= h_d;
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

/* sv/hrct_store.sv */
`default_nettype none
module hrct_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hrct_pkg::store_cmd_t  cmd_i,
  output hrct_pkg::store_rsp_t  rsp_o
);
  import hrct_pkg::*;

  ref_t   head_mem [BUCKETS];
  entry_t ent_mem  [CAPACITY];

  ref_t   head_rd_q;
  entry_t ent_rd_q;

  logic                clr_busy_q, clr_busy_d;
  logic [BUCKET_W-1:0] clr_addr_q, clr_addr_d;

  logic                head_we;
  logic [BUCKET_W-1:0] head_waddr;
  ref_t                head_wdata;

  // clearing pass over the bucket heads after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + BUCKET_W'(1);
      if (clr_addr_q == BUCKET_W'(BUCKETS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // head write port, clear sweep first
  assign head_we    = clr_busy_q | cmd_i.head_we;
  assign head_waddr = clr_busy_q ? clr_addr_q : cmd_i.head_waddr;
  assign head_wdata = clr_busy_q ? ref_t'('0) : cmd_i.head_wdata;

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[cmd_i.head_raddr];
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_we) begin
      ent_mem[cmd_i.ent_waddr] <= cmd_i.ent_wdata;
    end
    ent_rd_q <= ent_mem[cmd_i.ent_raddr];
  end

  assign rsp_o.head     = head_rd_q;
  assign rsp_o.ent      = ent_rd_q;
  assign rsp_o.clearing = clr_busy_q;

endmodule
`default_nettype wire

/* sv/hashed_roll_call_table_unit.sv */
`default_nettype none
// Roll-call table: a chained hash table of names of up to eight bytes, each
// with a called mark. An insert word puts the name at the head of its bucket
// chain (status inserted, or full once all entries are taken); a call word
// walks the chain and reports wrong, repeat, or ok after setting the mark.
// After reset the block sweeps all 4096 bucket heads, one per cycle, and
// holds in_stall_o high during the sweep. Then one word is taken at a time,
// with the name length clamped to 8. The hash unit folds in one byte per
// cycle and the walk reads one entry per cycle through the single read port
// of the entry memory. The result is held in an output register, so
// out_stall_i only delays the word after it.
module hashed_roll_call_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [hrct_pkg::NAME_W-1:0]     name_bytes_i,
  input  logic [hrct_pkg::LEN_W-1:0]      name_len_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hrct_pkg::STATUS_W-1:0]   status_o
);
  import hrct_pkg::*;

  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic [NAME_W-1:0]   name_q, name_d;
  logic [LEN_W-1:0]    len_q, len_d;
  status_e             status_q, status_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;

  logic                in_acc;
  logic [LEN_W-1:0]    len_c;
  logic [NAME_W-1:0]   name_c;
  logic                hash_done;
  logic [BUCKET_W-1:0] bucket;
  logic                full;
  logic                hit;
  store_cmd_t          cmd;
  store_rsp_t          rsp;

  assign in_stall_o = (state_q != S_IDLE) || rsp.clearing;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (used_q >= CNT_W'(CAPACITY));
  assign hit        = (rsp.ent.name == name_q) && (rsp.ent.len == len_q);

  // clamp the length and drop bytes beyond it
  always_comb begin
    len_c = (name_len_i > LEN_W'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES) : name_len_i;
    for (int i = 0; i < NAME_W / BYTE_W; i++) begin
      name_c[i*BYTE_W +: BYTE_W] = (LEN_W'(i) < len_c) ? name_bytes_i[i*BYTE_W +: BYTE_W]
                                                       : '0;
    end
  end

  hrct_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .step_i   (state_q == S_HASH),
    .name_i   (name_q),
    .len_i    (len_q),
    .done_o   (hash_done),
    .bucket_o (bucket)
  );

  hrct_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    name_d       = name_q;
    len_d        = len_q;
    status_d     = status_q;
    used_d       = used_q;
    ptr_d        = ptr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;

    cmd            = '0;
    cmd.head_raddr = bucket;
    cmd.head_waddr = bucket;
    cmd.ent_raddr  = ptr_q;
    cmd.ent_waddr  = ptr_q;

    // result register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d  = func_e'(func_i);
          name_d  = name_c;
          len_d   = len_c;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        // head read of the final bucket is issued in this cycle
        if (hash_done) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (func_q == FUNC_INSERT) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ent_we                = 1'b1;
            cmd.ent_waddr             = used_q[IDX_W-1:0];
            cmd.ent_wdata.name        = name_q;
            cmd.ent_wdata.len         = len_q;
            cmd.ent_wdata.called      = 1'b0;
            cmd.ent_wdata.next        = rsp.head;
            cmd.head_we               = 1'b1;
            cmd.head_wdata.valid      = 1'b1;
            cmd.head_wdata.idx        = used_q[IDX_W-1:0];
            used_d                    = used_q + CNT_W'(1);
            status_d                  = ST_INSERTED;
          end
          state_d = S_RESP;
        end else if (!rsp.head.valid) begin
          status_d = ST_WRONG;
          state_d  = S_RESP;
        end else begin
          cmd.ent_raddr = rsp.head.idx;
          ptr_d         = rsp.head.idx;
          state_d       = S_WALK;
        end
      end
      S_WALK: begin
        // one chain entry examined per cycle
        if (hit) begin
          if (rsp.ent.called) begin
            status_d = ST_REPEAT;
          end else begin
            cmd.ent_we            = 1'b1;
            cmd.ent_wdata         = rsp.ent;
            cmd.ent_wdata.called  = 1'b1;
            status_d              = ST_OK;
          end
          state_d = S_RESP;
        end else if (rsp.ent.next.valid) begin
          cmd.ent_raddr = rsp.ent.next.idx;
          ptr_d         = rsp.ent.next.idx;
        end else begin
          status_d = ST_WRONG;
          state_d  = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    name_q       <= name_d;
    len_q        <= len_d;
    status_q     <= status_d;
    ptr_q        <= ptr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  // entry count never passes the capacity
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // entry memory is written only while resolving a word
  a_ent_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ent_we |-> (state_q == S_HEAD || state_q == S_WALK))
    else $error("entry write outside head or walk");

  // a new result only comes out of the response step
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result raised outside response step");

  // a successful insert advances the entry count by one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEAD && func_q == FUNC_INSERT && !full)
      |=> used_q == $past(used_q) + CNT_W'(1))
    else $error("insert did not advance entry count");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
module tb;
  import hrct_pkg::*;

  // block ports
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                func_i       = 1'b0;
  logic [NAME_W-1:0]   name_bytes_i = '0;
  logic [LEN_W-1:0]    name_len_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [STATUS_W-1:0] status_o;

  hashed_roll_call_table_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .name_bytes_i (name_bytes_i),
    .name_len_i   (name_len_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the roll: bucket heads and entry store
  bit                head_set   [BUCKETS];
  int unsigned       head_idx   [BUCKETS];
  logic [NAME_W-1:0] roll_name  [CAPACITY];
  logic [LEN_W-1:0]  roll_len   [CAPACITY];
  bit                roll_called[CAPACITY];
  bit                link_set   [CAPACITY];
  int unsigned       link_idx   [CAPACITY];
  int unsigned       roll_count = 0;

  // names already on the roll, kept masked and with clamped length
  typedef struct {
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
  } roll_entry_t;
  roll_entry_t roll_pool[$];

  status_e     pending_status[$];
  status_e     status_want;
  int unsigned status_seen[5];
  int unsigned words_sent = 0;
  int unsigned bad_count  = 0;
  bit          idle_on    = 1'b1;
  int unsigned stall_left = 0;

  // byte mask of the valid part of a name
  function automatic logic [NAME_W-1:0] keep_mask(logic [LEN_W-1:0] len);
    if (len >= 4'd8) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  // random bytes above the valid part
  function automatic logic [NAME_W-1:0] with_noise(logic [NAME_W-1:0] name,
                                                   logic [LEN_W-1:0] len);
    return (name & keep_mask(len)) | ({$urandom, $urandom} & ~keep_mask(len));
  endfunction

  // mostly 1..8, now and then the empty name or an oversize length
  function automatic logic [LEN_W-1:0] draw_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  // roll update and status for one accepted word
  function automatic status_e roll_predict(func_e f, logic [NAME_W-1:0] nb,
                                           logic [LEN_W-1:0] nl);
    logic [LEN_W-1:0]  len;
    logic [NAME_W-1:0] name;
    logic [63:0]       h;
    int unsigned       b, p, steps, i;
    bit                live;
    status_e           st;
    len  = (nl > 4'd8) ? 4'd8 : nl;
    name = nb & keep_mask(len);
    h    = '0;
    for (i = 0; i < len; i++) h = h * 64'd131 + ((name >> (8 * i)) & 64'hFF);
    b = int'(h % 64'(BUCKETS));
    if (f == FUNC_INSERT) begin
      if (roll_count >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        roll_name[roll_count]   = name;
        roll_len[roll_count]    = len;
        roll_called[roll_count] = 1'b0;
        link_set[roll_count]    = head_set[b];
        link_idx[roll_count]    = head_idx[b];
        head_set[b]             = 1'b1;
        head_idx[b]             = roll_count;
        roll_count++;
        st = ST_INSERTED;
      end
    end else begin
      st    = ST_WRONG;
      live  = head_set[b];
      p     = head_idx[b];
      steps = 0;
      while (live && steps < CAPACITY) begin
        if (roll_name[p] == name && roll_len[p] == len) begin
          st             = roll_called[p] ? ST_REPEAT : ST_OK;
          roll_called[p] = 1'b1;
          break;
        end
        live = link_set[p];
        p    = link_idx[p];
        steps++;
      end
    end
    return st;
  endfunction

  // drive one word at the falling edge, hold it until taken
  task automatic present_word(input func_e f, input logic [NAME_W-1:0] nb,
                              input logic [LEN_W-1:0] nl);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    name_bytes_i <= nb;
    name_len_i   <= nl;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_status = {pending_status, roll_predict(f, nb, nl)};
    words_sent++;
  endtask

  // add a name to the pool of known names
  task automatic remember(input logic [NAME_W-1:0] nb, input logic [LEN_W-1:0] nl);
    roll_entry_t e;
    e.len  = (nl > 4'd8) ? 4'd8 : nl;
    e.name = nb & keep_mask(e.len);
    roll_pool = {roll_pool, e};
  endtask

  // hand-picked words: empty table, empty name, oversize length,
  // noise above the length, bucket collisions, duplicate inserts
  task automatic test_directed_cases();
    present_word(FUNC_CALL,   64'h0000_0000_0044_455A, 4'd3);
    present_word(FUNC_INSERT, 64'h0000_0000_0000_0041, 4'd1);
    present_word(FUNC_CALL,   64'h0000_0000_0000_0041, 4'd1);
    present_word(FUNC_CALL,   64'h0000_0000_0000_0041, 4'd1);
    present_word(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    present_word(FUNC_CALL,   64'h0000_0000_0000_0000, 4'd0);
    present_word(FUNC_CALL,   64'h1234_5678_9ABC_DEF0, 4'd0);
    present_word(FUNC_INSERT, 64'h0000_0000_0000_0000, 4'd8);
    present_word(FUNC_CALL,   64'h0000_0000_0000_0000, 4'd7);
    present_word(FUNC_CALL,   64'h0000_0000_0000_0000, 4'd8);
    present_word(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    present_word(FUNC_CALL,   64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    present_word(FUNC_CALL,   64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
    present_word(FUNC_INSERT, 64'hDEAD_BEEF_CAFE_0042, 4'd1);
    present_word(FUNC_CALL,   64'h0000_0000_0000_0042, 4'd1);
    // both names hash to 131
    present_word(FUNC_INSERT, 64'h0000_0000_0000_8300, 4'd2);
    present_word(FUNC_INSERT, 64'h0000_0000_0000_0001, 4'd2);
    present_word(FUNC_CALL,   64'h0000_0000_0000_0001, 4'd2);
    present_word(FUNC_CALL,   64'h5555_0000_0000_8300, 4'd2);
    present_word(FUNC_CALL,   64'h0000_0000_0000_8301, 4'd2);
    // newer copy shadows the older one
    present_word(FUNC_INSERT, 64'h0000_0000_0042_4F42, 4'd3);
    present_word(FUNC_INSERT, 64'h0000_0000_0042_4F42, 4'd3);
    present_word(FUNC_CALL,   64'h0000_0000_0042_4F42, 4'd3);
    present_word(FUNC_CALL,   64'h0000_0000_0042_4F42, 4'd3);
    present_word(FUNC_CALL,   64'h0000_0000_0042_4F42, 4'd4);
  endtask

  // mostly calls, of known and of unknown names, with fresh and duplicate inserts mixed in
  task automatic test_random_roll();
    int unsigned       k, r, pick;
    logic [NAME_W-1:0] nb;
    logic [LEN_W-1:0]  nl;
    roll_entry_t       e;
    for (k = 0; k < 1150; k++) begin
      if (k % 125 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (roll_pool.size() != 0) begin
        pick = $urandom_range(0, roll_pool.size() - 1);
        e    = roll_pool[pick];
      end
      if (roll_pool.size() == 0 || r < 35) begin
        nl = draw_len();
        nb = {$urandom, $urandom};
        // narrow alphabet so that short names share buckets
        if ($urandom_range(0, 1) == 1) nb = nb & 64'h0303_0303_0303_0303;
        present_word(FUNC_INSERT, nb, nl);
        remember(nb, nl);
      end else if (r < 45) begin
        present_word(FUNC_INSERT, with_noise(e.name, e.len), e.len);
      end else if (r < 80) begin
        nl = e.len;
        if (e.len == 4'd8 && $urandom_range(0, 1) == 1) nl = 4'($urandom_range(8, 15));
        present_word(FUNC_CALL, with_noise(e.name, e.len), nl);
      end else if (r < 90) begin
        present_word(FUNC_CALL, {$urandom, $urandom}, draw_len());
      end else begin
        nl = (e.len == 4'd0) ? 4'd1 : e.len - 4'd1;
        present_word(FUNC_CALL, e.name, nl);
      end
    end
  endtask

  // closing stretch with no idling: calls of known names and of strangers
  task automatic test_quiet_calls();
    int unsigned k;
    roll_entry_t e;
    idle_on = 1'b0;
    for (k = 0; k < 40; k++) begin
      e = roll_pool[$urandom_range(0, roll_pool.size() - 1)];
      present_word(FUNC_CALL, with_noise(e.name, e.len), e.len);
      present_word(FUNC_CALL, {$urandom, $urandom}, draw_len());
    end
  endtask

  // result side stall bursts
  always @(negedge clk_i) begin
    if (!idle_on) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(0, 99) < 8) stall_left = $urandom_range(1, 18);
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // compare each accepted status word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_status.size() == 0) begin
        if (bad_count < 10) $display("status word %0d with none pending", status_o);
        bad_count++;
      end else begin
        status_want = pending_status.pop_front();
        if (status_o !== status_want) begin
          if (bad_count < 10) begin
            $display("status mismatch: expected %0d got %0d", status_want, status_o);
          end
          bad_count++;
        end else begin
          status_seen[status_want]++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d status words pending", pending_status.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_roll();
    test_quiet_calls();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    $display("%0d words sent: ok %0d, repeat %0d, wrong %0d, inserted %0d, full %0d",
             words_sent, status_seen[ST_OK], status_seen[ST_REPEAT], status_seen[ST_WRONG],
             status_seen[ST_INSERTED], status_seen[ST_FULL]);
    $display("entry store filled to %0d of %0d, %0d mismatches", roll_count, CAPACITY,
             bad_count);
    if (bad_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
